### src/ghp_pkg.sv
`default_nettype none

package ghp_pkg;

  // width of the byte counter and of the reported header length
  localparam int unsigned LENGTH_BITS = 24;

  // fixed header bytes and flag masks
  localparam logic [7:0] GZ_ID1        = 8'h1f;
  localparam logic [7:0] GZ_ID2        = 8'h8b;
  localparam logic [7:0] GZ_CM_DEFLATE = 8'h08;
  localparam logic [7:0] FLG_RESERVED  = 8'he0;
  localparam logic [7:0] FLG_FEXTRA    = 8'h04;
  localparam logic [7:0] FLG_FNAME     = 8'h08;
  localparam logic [7:0] FLG_FCOMMENT  = 8'h10;
  localparam logic [7:0] FLG_FHCRC     = 8'h02;

  // byte positions inside the fixed header
  localparam logic [LENGTH_BITS-1:0] IDX_ID1  = LENGTH_BITS'(0);
  localparam logic [LENGTH_BITS-1:0] IDX_ID2  = LENGTH_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] IDX_CM   = LENGTH_BITS'(2);
  localparam logic [LENGTH_BITS-1:0] IDX_FLG  = LENGTH_BITS'(3);
  localparam logic [LENGTH_BITS-1:0] IDX_LAST = LENGTH_BITS'(9);
  localparam logic [LENGTH_BITS-1:0] CNT_MAX  = '1;

  // optional parts still to walk
  localparam int unsigned OPT_EXTRA   = 0;
  localparam int unsigned OPT_NAME    = 1;
  localparam int unsigned OPT_COMMENT = 2;
  localparam int unsigned OPT_CRC     = 3;

  typedef enum logic [7:0] {
    PH_FIXED   = 8'b0000_0001,
    PH_XLEN_LO = 8'b0000_0010,
    PH_XLEN_HI = 8'b0000_0100,
    PH_EXTRA   = 8'b0000_1000,
    PH_NAME    = 8'b0001_0000,
    PH_COMMENT = 8'b0010_0000,
    PH_CRC_LO  = 8'b0100_0000,
    PH_CRC_HI  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic [LENGTH_BITS-1:0] byte_count;
    logic [3:0]             option_flags;
    logic [15:0]            extra_remaining;
    logic [7:0]             extra_len_low;
    logic                   answered;
  } ghp_state_t;

  typedef struct packed {
    logic                   vld;
    logic                   ok;
    logic [LENGTH_BITS-1:0] len;
  } ghp_result_t;

  localparam ghp_state_t GHP_STATE_RST = '{
    phase:           PH_FIXED,
    byte_count:      '0,
    option_flags:    '0,
    extra_remaining: '0,
    extra_len_low:   '0,
    answered:        1'b0
  };

endpackage

`default_nettype wire

### src/ghp_step.sv
`default_nettype none

module ghp_step (
  input  wire ghp_pkg::ghp_state_t  st,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 last_byte,
  output ghp_pkg::ghp_state_t       st_nxt,
  output ghp_pkg::ghp_result_t      res
);

  typedef enum logic [1:0] {
    GO_ON  = 2'd0,
    GO_OK  = 2'd1,
    GO_BAD = 2'd2
  } go_t;

  logic [3:0]                      ent_flags;
  ghp_pkg::phase_t                 ent_phase;
  logic                            ent_done;
  logic [ghp_pkg::LENGTH_BITS-1:0] cnt_inc;
  logic [15:0]                     xlen;
  logic [15:0]                     xrem_dec;
  go_t                             go;

  // pick the next optional part, in header order
  always_comb begin
    ent_flags = st.option_flags;
    ent_phase = st.phase;
    ent_done  = 1'b0;
    if (st.option_flags[ghp_pkg::OPT_EXTRA]) begin
      ent_flags[ghp_pkg::OPT_EXTRA] = 1'b0;
      ent_phase = ghp_pkg::PH_XLEN_LO;
    end else if (st.option_flags[ghp_pkg::OPT_NAME]) begin
      ent_flags[ghp_pkg::OPT_NAME] = 1'b0;
      ent_phase = ghp_pkg::PH_NAME;
    end else if (st.option_flags[ghp_pkg::OPT_COMMENT]) begin
      ent_flags[ghp_pkg::OPT_COMMENT] = 1'b0;
      ent_phase = ghp_pkg::PH_COMMENT;
    end else if (st.option_flags[ghp_pkg::OPT_CRC]) begin
      ent_flags[ghp_pkg::OPT_CRC] = 1'b0;
      ent_phase = ghp_pkg::PH_CRC_LO;
    end else begin
      ent_done = 1'b1;
    end
  end

  assign cnt_inc  = st.byte_count + 1'b1;
  assign xlen     = {data_byte, st.extra_len_low};
  assign xrem_dec = st.extra_remaining - 16'd1;

  // one byte of state update
  always_comb begin
    st_nxt = st;
    go     = GO_ON;
    res    = '0;
    if (st.answered) begin
      // waiting for the end of the buffer
      if (last_byte) begin
        st_nxt = ghp_pkg::GHP_STATE_RST;
      end
    end else begin
      if (st.byte_count == ghp_pkg::CNT_MAX) begin
        go = GO_BAD;
      end else begin
        st_nxt.byte_count = cnt_inc;
        case (st.phase)
          ghp_pkg::PH_FIXED: begin
            if (st.byte_count == ghp_pkg::IDX_ID1) begin
              if (data_byte != ghp_pkg::GZ_ID1) go = GO_BAD;
            end else if (st.byte_count == ghp_pkg::IDX_ID2) begin
              if (data_byte != ghp_pkg::GZ_ID2) go = GO_BAD;
            end else if (st.byte_count == ghp_pkg::IDX_CM) begin
              if (data_byte != ghp_pkg::GZ_CM_DEFLATE) go = GO_BAD;
            end else if (st.byte_count == ghp_pkg::IDX_FLG) begin
              if ((data_byte & ghp_pkg::FLG_RESERVED) != 8'h00) begin
                go = GO_BAD;
              end else begin
                st_nxt.option_flags[ghp_pkg::OPT_EXTRA] =
                  |(data_byte & ghp_pkg::FLG_FEXTRA);
                st_nxt.option_flags[ghp_pkg::OPT_NAME] =
                  |(data_byte & ghp_pkg::FLG_FNAME);
                st_nxt.option_flags[ghp_pkg::OPT_COMMENT] =
                  |(data_byte & ghp_pkg::FLG_FCOMMENT);
                st_nxt.option_flags[ghp_pkg::OPT_CRC] =
                  |(data_byte & ghp_pkg::FLG_FHCRC);
              end
            end else if (st.byte_count == ghp_pkg::IDX_LAST) begin
              if (ent_done) begin
                go = GO_OK;
              end else begin
                st_nxt.option_flags = ent_flags;
                st_nxt.phase        = ent_phase;
              end
            end
          end
          ghp_pkg::PH_XLEN_LO: begin
            st_nxt.extra_len_low = data_byte;
            st_nxt.phase         = ghp_pkg::PH_XLEN_HI;
          end
          ghp_pkg::PH_XLEN_HI: begin
            st_nxt.extra_remaining = xlen;
            if (xlen == 16'd0) begin
              if (ent_done) begin
                go = GO_OK;
              end else begin
                st_nxt.option_flags = ent_flags;
                st_nxt.phase        = ent_phase;
              end
            end else begin
              st_nxt.phase = ghp_pkg::PH_EXTRA;
            end
          end
          ghp_pkg::PH_EXTRA: begin
            st_nxt.extra_remaining = xrem_dec;
            if (xrem_dec == 16'd0) begin
              if (ent_done) begin
                go = GO_OK;
              end else begin
                st_nxt.option_flags = ent_flags;
                st_nxt.phase        = ent_phase;
              end
            end
          end
          ghp_pkg::PH_NAME, ghp_pkg::PH_COMMENT: begin
            if (data_byte == 8'h00) begin
              if (ent_done) begin
                go = GO_OK;
              end else begin
                st_nxt.option_flags = ent_flags;
                st_nxt.phase        = ent_phase;
              end
            end
          end
          ghp_pkg::PH_CRC_LO: begin
            st_nxt.phase = ghp_pkg::PH_CRC_HI;
          end
          ghp_pkg::PH_CRC_HI: begin
            if (ent_done) begin
              go = GO_OK;
            end else begin
              st_nxt.option_flags = ent_flags;
              st_nxt.phase        = ent_phase;
            end
          end
          default: begin
            go = GO_BAD;
          end
        endcase
      end

      // buffer ended before the header did
      if (go == GO_ON && last_byte) go = GO_BAD;

      // verdict reached
      if (go != GO_ON) begin
        res.vld = 1'b1;
        res.ok  = (go == GO_OK);
        res.len = (go == GO_OK) ? cnt_inc : '0;
        if (last_byte) begin
          st_nxt = ghp_pkg::GHP_STATE_RST;
        end else begin
          st_nxt.answered = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### src/gzip_header_parser_core.sv
`default_nettype none

// gzip member header checker: takes one byte of a buffer per cycle unless
// in_stall is high, with the final byte flagged by in_last_byte, and returns
// one request per buffer with header_ok and the header length in bytes (0 when
// invalid). The verdict comes on the byte that completes the header, proves it
// bad, or ends the buffer; later bytes up to the buffer's last are swallowed
// silently. A byte goes through an input register and then the result
// register before its result is offered; the parser state updates once per
// byte, so the sustained rate is one byte per clock while out_stall is low.
module gzip_header_parser_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_data_byte,
  input  wire logic                            in_last_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_header_ok,
  output logic [ghp_pkg::LENGTH_BITS-1:0]      out_header_length
);

  logic                            in_vld_r;
  logic [7:0]                      in_byte_r;
  logic                            in_last_r;
  ghp_pkg::ghp_state_t             st_r;
  ghp_pkg::ghp_state_t             st_nxt;
  ghp_pkg::ghp_result_t            res;
  logic                            out_vld_r;
  logic                            out_ok_r;
  logic [ghp_pkg::LENGTH_BITS-1:0] out_len_r;
  logic                            adv;
  logic                            in_load;

  // process stage moves when the result register is free or being drained
  assign adv      = !out_vld_r || !out_stall;
  assign in_load  = !in_vld_r || adv;
  assign in_stall = in_vld_r && !adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_load) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  // per-byte parser step
  ghp_step u_step (
    .st        (st_r),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ghp_pkg::GHP_STATE_RST;
    end else if (in_vld_r && adv) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r && res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_vld_r && res.vld) begin
      out_ok_r  <= res.ok;
      out_len_r <= res.len;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_header_ok     = out_ok_r;
  assign out_header_length = out_len_r;

`ifndef SYNTHESIS
  // an invalid verdict never carries a length
  a_bad_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_header_ok |-> out_header_length == '0)
    else $error("invalid header reported with non-zero length");

  // a valid header holds at least the fixed part
  a_ok_len_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_header_ok |-> out_header_length > ghp_pkg::IDX_LAST)
    else $error("valid header shorter than the fixed part");

  // once answered, nothing more is reported for the buffer
  a_answered_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && st_r.answered |-> !res.vld)
    else $error("second result for one buffer");
`endif

endmodule

`default_nettype wire

### sim/gzip_header_parser_core_test.sv
module gzip_header_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] FLG_FTEXT = 8'h01;
  localparam int RANDOM_BYTES = 1400;
  localparam int SEGMENT_BYTES = 300;
  localparam int DRAIN_CYCLES = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int LONG_EXTRA_BYTES = 258;

  typedef logic [7:0] octet_q_t[$];

  typedef struct packed {
    logic                            ok;
    logic [ghp_pkg::LENGTH_BITS-1:0] len;
  } verdict_t;

  typedef enum {STEP_MORE, STEP_OK, STEP_BAD} step_t;
  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [7:0]                      in_data_byte;
  logic                            in_last_byte;
  logic                            out_valid;
  logic                            out_stall;
  logic                            out_header_ok;
  logic [ghp_pkg::LENGTH_BITS-1:0] out_header_length;

  // header parser state mirrored by the checker
  ghp_pkg::phase_t                 parse_phase;
  logic [ghp_pkg::LENGTH_BITS-1:0] parse_count;
  logic [3:0]                      parts_left;
  logic [15:0]                     extra_left;
  logic [7:0]                      extra_low;
  logic                            verdict_given;

  verdict_t    expected_verdicts[$];
  verdict_t    oldest_verdict;
  int          mismatches;
  int          idle_cycles;

  // sender and receiver idling controls
  int          gap_max;
  int          burst_max;
  int          burst_left;
  stall_mode_t stall_mode;
  int          stall_pct;
  logic [15:0] stall_pattern;
  int          hold_request;
  int          hold_left;

  gzip_header_parser_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_header_ok     (out_header_ok),
    .out_header_length (out_header_length)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // parser model
  function automatic void restart_parser();
    parse_phase   = ghp_pkg::PH_FIXED;
    parse_count   = '0;
    parts_left    = '0;
    extra_left    = '0;
    extra_low     = '0;
    verdict_given = 1'b0;
  endfunction

  function automatic step_t next_part();
    if (parts_left[ghp_pkg::OPT_EXTRA]) begin
      parts_left[ghp_pkg::OPT_EXTRA] = 1'b0;
      parse_phase = ghp_pkg::PH_XLEN_LO;
      return STEP_MORE;
    end
    if (parts_left[ghp_pkg::OPT_NAME]) begin
      parts_left[ghp_pkg::OPT_NAME] = 1'b0;
      parse_phase = ghp_pkg::PH_NAME;
      return STEP_MORE;
    end
    if (parts_left[ghp_pkg::OPT_COMMENT]) begin
      parts_left[ghp_pkg::OPT_COMMENT] = 1'b0;
      parse_phase = ghp_pkg::PH_COMMENT;
      return STEP_MORE;
    end
    if (parts_left[ghp_pkg::OPT_CRC]) begin
      parts_left[ghp_pkg::OPT_CRC] = 1'b0;
      parse_phase = ghp_pkg::PH_CRC_LO;
      return STEP_MORE;
    end
    return STEP_OK;
  endfunction

  function automatic step_t take_header_byte(logic [7:0] b,
                                             logic [ghp_pkg::LENGTH_BITS-1:0] idx);
    case (parse_phase)
      ghp_pkg::PH_FIXED: begin
        if (idx == ghp_pkg::IDX_ID1 && b != ghp_pkg::GZ_ID1) return STEP_BAD;
        if (idx == ghp_pkg::IDX_ID2 && b != ghp_pkg::GZ_ID2) return STEP_BAD;
        if (idx == ghp_pkg::IDX_CM && b != ghp_pkg::GZ_CM_DEFLATE) return STEP_BAD;
        if (idx == ghp_pkg::IDX_FLG) begin
          if ((b & ghp_pkg::FLG_RESERVED) != 8'h00) return STEP_BAD;
          parts_left = {(b & ghp_pkg::FLG_FHCRC) != 8'h00,
                        (b & ghp_pkg::FLG_FCOMMENT) != 8'h00,
                        (b & ghp_pkg::FLG_FNAME) != 8'h00,
                        (b & ghp_pkg::FLG_FEXTRA) != 8'h00};
        end
        if (idx >= ghp_pkg::IDX_LAST) return next_part();
        return STEP_MORE;
      end
      ghp_pkg::PH_XLEN_LO: begin
        extra_low = b;
        parse_phase = ghp_pkg::PH_XLEN_HI;
        return STEP_MORE;
      end
      ghp_pkg::PH_XLEN_HI: begin
        extra_left = {b, extra_low};
        if (extra_left == 16'h0000) return next_part();
        parse_phase = ghp_pkg::PH_EXTRA;
        return STEP_MORE;
      end
      ghp_pkg::PH_EXTRA: begin
        extra_left = extra_left - 16'd1;
        if (extra_left == 16'h0000) return next_part();
        return STEP_MORE;
      end
      ghp_pkg::PH_NAME, ghp_pkg::PH_COMMENT: begin
        if (b == 8'h00) return next_part();
        return STEP_MORE;
      end
      ghp_pkg::PH_CRC_LO: begin
        parse_phase = ghp_pkg::PH_CRC_HI;
        return STEP_MORE;
      end
      ghp_pkg::PH_CRC_HI: return next_part();
      default: return STEP_BAD;
    endcase
  endfunction

  // one accepted byte: update the model and queue any verdict it gives
  function automatic void parse_byte(logic [7:0] b, logic last);
    logic [ghp_pkg::LENGTH_BITS-1:0] idx;
    step_t                           step;
    verdict_t                        verdict;
    if (verdict_given) begin
      if (last) restart_parser();
      return;
    end
    idx = parse_count;
    if (idx == ghp_pkg::CNT_MAX) begin
      step = STEP_BAD;
    end else begin
      parse_count = idx + 1'b1;
      step = take_header_byte(b, idx);
    end
    if (step == STEP_MORE && last) step = STEP_BAD;
    if (step == STEP_MORE) return;
    verdict.ok  = (step == STEP_OK);
    verdict.len = (step == STEP_OK) ? parse_count : '0;
    expected_verdicts = {expected_verdicts, verdict};
    if (last) restart_parser();
    else verdict_given = 1'b1;
  endfunction

  // result check first, then the model takes the accepted request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result: header_ok %0b header_length %0d",
                 out_header_ok, out_header_length);
          mismatches++;
        end else begin
          oldest_verdict = expected_verdicts.pop_front();
          if (out_header_ok !== oldest_verdict.ok) begin
            $error("header_ok: expected %0b, actual %0b", oldest_verdict.ok, out_header_ok);
            mismatches++;
          end
          if (out_header_length !== oldest_verdict.len) begin
            $error("header_length: expected %0d, actual %0d",
                   oldest_verdict.len, out_header_length);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) parse_byte(in_data_byte, in_last_byte);
    end
  end

  // receiver stall, with a counted hold-off on request
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      case (stall_mode)
        STALL_RANDOM: out_stall <= ($urandom_range(99) < stall_pct);
        STALL_PATTERN: begin
          out_stall <= stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic set_idling(int mode);
    burst_left = 0;
    case (mode)
      1: begin
        gap_max = 6;
        burst_max = 8;
        stall_mode = STALL_RANDOM;
        stall_pct = 30;
      end
      2: begin
        gap_max = 2;
        burst_max = 3;
        stall_mode = STALL_PATTERN;
        stall_pattern = 16'($urandom_range(16'hfffe));
      end
      3: begin
        gap_max = 0;
        stall_mode = STALL_RANDOM;
        stall_pct = 70;
      end
      default: begin
        gap_max = 0;
        stall_mode = STALL_NONE;
      end
    endcase
  endtask

  // one request, preceded by a gap at the end of each burst
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (gap_max > 0 && burst_left == 0) begin
      burst_left = $urandom_range(burst_max, 1);
      gap = $urandom_range(gap_max, 1);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_buffer(octet_q_t octets);
    foreach (octets[i]) send_byte(octets[i], i == octets.size() - 1);
  endtask

  task automatic wait_verdicts();
    @(negedge clk) in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // well-formed header with random time, xfl, os, field content and crc
  function automatic octet_q_t build_header(logic [7:0] flags, int xlen, int name_len,
                                            int comment_len);
    octet_q_t hdr;
    hdr = {hdr, ghp_pkg::GZ_ID1};
    hdr = {hdr, ghp_pkg::GZ_ID2};
    hdr = {hdr, ghp_pkg::GZ_CM_DEFLATE};
    hdr = {hdr, flags};
    repeat (6) hdr = {hdr, 8'($urandom_range(255))};
    if ((flags & ghp_pkg::FLG_FEXTRA) != 8'h00) begin
      hdr = {hdr, xlen[7:0]};
      hdr = {hdr, xlen[15:8]};
      repeat (xlen) hdr = {hdr, 8'($urandom_range(255))};
    end
    if ((flags & ghp_pkg::FLG_FNAME) != 8'h00) begin
      repeat (name_len) hdr = {hdr, 8'($urandom_range(255, 1))};
      hdr = {hdr, 8'h00};
    end
    if ((flags & ghp_pkg::FLG_FCOMMENT) != 8'h00) begin
      repeat (comment_len) hdr = {hdr, 8'($urandom_range(255, 1))};
      hdr = {hdr, 8'h00};
    end
    if ((flags & ghp_pkg::FLG_FHCRC) != 8'h00) begin
      repeat (2) hdr = {hdr, 8'($urandom_range(255))};
    end
    return hdr;
  endfunction

  function automatic octet_q_t first_bytes(octet_q_t src, int n);
    while (src.size() > n) void'(src.pop_back());
    return src;
  endfunction

  // bare fixed header, answered on the last byte, and a text-flag header with trailing bytes
  task automatic test_plain_headers();
    octet_q_t octets;
    send_buffer(build_header(8'h00, 0, 0, 0));
    octets = build_header(FLG_FTEXT, 0, 0, 0);
    repeat (2) octets = {octets, 8'($urandom_range(255))};
    send_buffer(octets);
  endtask

  // bad magic, bad method and each reserved flag bit
  task automatic test_broken_fixed_fields();
    octet_q_t octets;
    octets = {octets, 8'hff};
    send_buffer(octets);
    octets = build_header(8'h00, 0, 0, 0);
    octets[1] = 8'h8a;
    send_buffer(octets);
    octets = first_bytes(build_header(8'h00, 0, 0, 0), 5);
    octets[2] = 8'h07;
    send_buffer(octets);
    for (int bit_pos = 5; bit_pos < 8; bit_pos++) begin
      octets = first_bytes(build_header(8'h00, 0, 0, 0), 4);
      octets[3] = 8'(1 << bit_pos) | ghp_pkg::FLG_FNAME;
      send_buffer(octets);
    end
  endtask

  // each optional part alone, zero-length extra and all parts together
  task automatic test_optional_parts();
    send_buffer(build_header(ghp_pkg::FLG_FEXTRA, 0, 0, 0));
    send_buffer(build_header(ghp_pkg::FLG_FEXTRA, 3, 0, 0));
    send_buffer(build_header(ghp_pkg::FLG_FNAME, 0, 4, 0));
    send_buffer(build_header(ghp_pkg::FLG_FCOMMENT, 0, 0, 0));
    send_buffer(build_header(ghp_pkg::FLG_FHCRC, 0, 0, 0));
    send_buffer(build_header(8'h1f, 2, 2, 2));
  endtask

  // buffers that end before the header is complete
  task automatic test_truncation();
    octet_q_t octets;
    octets = {octets, ghp_pkg::GZ_ID1};
    send_buffer(octets);
    send_buffer(first_bytes(build_header(8'h00, 0, 0, 0), 6));
    send_buffer(first_bytes(build_header(ghp_pkg::FLG_FEXTRA, 4, 0, 0), 11));
    octets = build_header(ghp_pkg::FLG_FNAME, 0, 5, 0);
    send_buffer(first_bytes(octets, octets.size() - 3));
  endtask

  // extra length that needs both length bytes, at full rate
  task automatic test_long_extra();
    set_idling(0);
    send_buffer(build_header(ghp_pkg::FLG_FEXTRA | ghp_pkg::FLG_FHCRC,
                             LONG_EXTRA_BYTES, 0, 0));
  endtask

  // receiver holds off while one-byte bad buffers keep coming, so the input backs up
  task automatic test_output_hold_off();
    logic [7:0] b;
    wait_verdicts();
    set_idling(0);
    hold_request = HOLD_OFF_CYCLES;
    repeat (60) begin
      b = 8'($urandom_range(255));
      if (b == ghp_pkg::GZ_ID1) b = 8'h00;
      send_byte(b, 1'b1);
    end
    wait_verdicts();
  endtask

  // mostly well-formed headers, some cut short or damaged, some noise
  task automatic test_random_buffers();
    octet_q_t   octets;
    int         sent;
    int         segment_end;
    int         kind;
    int         xlen;
    logic [7:0] flags;
    sent = 0;
    segment_end = 0;
    while (sent < RANDOM_BYTES) begin
      if (sent >= segment_end) begin
        set_idling(sent == 0 ? 0 : $urandom_range(3));
        segment_end = sent + SEGMENT_BYTES;
      end
      kind  = $urandom_range(99);
      flags = 8'($urandom_range(255)) & ~ghp_pkg::FLG_RESERVED;
      xlen  = ($urandom_range(19) == 0) ? $urandom_range(600) : $urandom_range(6);
      octets = build_header(flags, xlen, $urandom_range(5), $urandom_range(5));
      if (kind < 65) begin
        repeat ($urandom_range(3)) octets = {octets, 8'($urandom_range(255))};
      end else if (kind < 80) begin
        octets = first_bytes(octets, $urandom_range(octets.size(), 1));
      end else if (kind < 90) begin
        octets[$urandom_range(3)] = 8'($urandom_range(255));
        repeat ($urandom_range(3)) octets = {octets, 8'($urandom_range(255))};
      end else begin
        octets.delete();
        repeat ($urandom_range(12, 1)) octets = {octets, 8'($urandom_range(255))};
      end
      send_buffer(octets);
      sent += octets.size();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    in_last_byte = 1'b0;
    out_stall    = 1'b0;
    mismatches   = 0;
    hold_request = 0;
    hold_left    = 0;
    stall_pct    = 0;
    stall_pattern = 16'h0000;
    set_idling(0);
    restart_parser();
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    set_idling(1);
    test_plain_headers();
    test_broken_fixed_fields();
    test_optional_parts();
    test_truncation();
    test_long_extra();
    test_output_hold_off();
    test_random_buffers();
    wait_verdicts();

    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
